// ===== rtl/core/fstk_pkg.sv =====
// Shared types and constants for the fuzzy subsequence top-K matcher.
`timescale 1ns / 1ps

package fstk_pkg;

  // Parameter defaults
  localparam int unsigned QUERY_MAX_DEF  = 32;
  localparam int unsigned SYMBOL_MAX_DEF = 1024;
  localparam int unsigned TOP_K_DEF      = 8;

  // Fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned GAP_W     = 10;
  localparam int unsigned LEN_OUT_W = 11;
  localparam int unsigned QLEN_W    = 6;
  localparam int unsigned RLIM_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  // Report limit ceiling and gap saturation
  localparam int unsigned    REPORT_MAX     = 8;
  localparam logic [GAP_W-1:0]  GAP_SAT     = 10'd1023;
  localparam logic [RLIM_W-1:0] RLIM_RST    = 4'd8;

  // ASCII case folding
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_0_7    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_8_15   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_16_23  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_24_31  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_SEL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LIMIT = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [QLEN_W-1:0]        query_length;
    logic [31:0][CHAR_W-1:0]  query_chars;
    logic                     fold_case;
    logic                     method_sel;
    logic [RLIM_W-1:0]        report_limit;
  } fstk_cfg_t;

  // Commands into the best-list sequencer
  typedef struct packed {
    logic ins;
    logic rpt;
  } fstk_cmd_t;

endpackage

// ===== rtl/core/fstk_if.sv =====
// Valid/ready channel interfaces for input, result and configuration transfers.
`timescale 1ns / 1ps

interface fstk_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  char_code;
  logic        last_of_symbol;
  logic        symbol_is_method;
  logic [15:0] tag_index;

  modport source (output valid, mode, char_code, last_of_symbol, symbol_is_method, tag_index,
                  input ready);
  modport sink   (input valid, mode, char_code, last_of_symbol, symbol_is_method, tag_index,
                  output ready);
endinterface

interface fstk_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] match_tag;
  logic [9:0]  gap_count;
  logic [10:0] symbol_length;
  logic        none_found;
  logic        last_result;

  modport source (output valid, match_tag, gap_count, symbol_length, none_found, last_result,
                  input ready);
  modport sink   (input valid, match_tag, gap_count, symbol_length, none_found, last_result,
                  output ready);
endinterface

interface fstk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fstk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fstk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fstk_match.sv =====
// Per-character greedy subsequence match with gap accumulation.
`timescale 1ns / 1ps

module fstk_match import fstk_pkg::*; #(
  parameter int unsigned QUERY_MAX  = QUERY_MAX_DEF,
  parameter int unsigned SYMBOL_MAX = SYMBOL_MAX_DEF,
  localparam int unsigned POS_W = $clog2(SYMBOL_MAX + 1),
  localparam int unsigned ENT_W = TAG_W + GAP_W + POS_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_acc,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_of_symbol,
  input  logic              symbol_is_method,
  input  logic [TAG_W-1:0]  tag_index,
  input  fstk_cfg_t         cfg,
  output logic              ins_valid,
  output logic [ENT_W-1:0]  ins_entry
);

  localparam int unsigned QP_W = $clog2(QUERY_MAX + 1);
  localparam int unsigned GS_W = ((POS_W > GAP_W) ? POS_W : GAP_W) + 1;
  localparam logic [QLEN_W-1:0] QLEN_CAP  = QLEN_W'(QUERY_MAX);
  localparam logic [POS_W-1:0]  SYM_MAX_C = POS_W'(SYMBOL_MAX);

  logic [QP_W-1:0]   qp_r, qp_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  logic              any_r, any_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [POS_W-1:0]  spos_r, spos_nxt;

  logic [CHAR_W-1:0] c_low;
  logic [QLEN_W-1:0] qlen_act;
  logic              hit;
  logic [POS_W-1:0]  diff;
  logic [GS_W-1:0]   gap_sum;
  logic [GAP_W-1:0]  gap_upd;

  // Case folding, query byte compare and saturating gap update
  always_comb begin
    c_low = char_code;
    if (cfg.fold_case && char_code >= ASCII_UPPER_A && char_code <= ASCII_UPPER_Z) begin
      c_low = char_code + ASCII_CASE_OFS;
    end
    qlen_act = (cfg.query_length > QLEN_CAP) ? QLEN_CAP : cfg.query_length;
    hit      = (QLEN_W'(qp_r) < qlen_act) && (c_low == cfg.query_chars[5'(qp_r)]);
    diff     = spos_r - last_r - 1'b1;
    gap_sum  = GS_W'(gap_r) + GS_W'(diff);
    gap_upd  = (gap_sum > GS_W'(GAP_SAT)) ? GAP_SAT : gap_sum[GAP_W-1:0];

    qp_nxt   = qp_r;
    last_nxt = last_r;
    any_nxt  = any_r;
    gap_nxt  = gap_r;
    if (hit) begin
      if (any_r && spos_r > last_r) begin
        gap_nxt = gap_upd;
      end
      last_nxt = spos_r;
      any_nxt  = 1'b1;
      qp_nxt   = qp_r + 1'b1;
    end
    spos_nxt = (spos_r < SYM_MAX_C) ? spos_r + 1'b1 : spos_r;

    // Completed symbol of the requested kind that holds the whole query goes to the list
    ins_valid = char_acc && last_of_symbol && (symbol_is_method == cfg.method_sel) &&
                (QLEN_W'(qp_nxt) >= qlen_act);
    ins_entry = {tag_index, gap_nxt, spos_nxt};
  end

  // Symbol match state, cleared at the end of each symbol
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r   <= '0;
      last_r <= '0;
      any_r  <= 1'b0;
      gap_r  <= '0;
      spos_r <= '0;
    end else if (char_acc) begin
      if (last_of_symbol) begin
        qp_r   <= '0;
        last_r <= '0;
        any_r  <= 1'b0;
        gap_r  <= '0;
        spos_r <= '0;
      end else begin
        qp_r   <= qp_nxt;
        last_r <= last_nxt;
        any_r  <= any_nxt;
        gap_r  <= gap_nxt;
        spos_r <= spos_nxt;
      end
    end
  end

  // Match state invariants
  a_qp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qp_r <= QP_W'(QUERY_MAX))
    else $error("query position beyond query maximum");
  a_any_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (qp_r == '0 && gap_r == '0))
    else $error("progress recorded without a match");
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (char_acc && last_of_symbol) |=> (spos_r == '0 && qp_r == '0))
    else $error("symbol state not cleared after final character");

endmodule

// ===== rtl/core/fstk_list.sv =====
// Sorted best-list sequencer: one shared compare per cycle for insertion, report readout.
`timescale 1ns / 1ps

module fstk_list import fstk_pkg::*; #(
  parameter int unsigned TOP_K      = TOP_K_DEF,
  parameter int unsigned SYMBOL_MAX = SYMBOL_MAX_DEF,
  localparam int unsigned POS_W = $clog2(SYMBOL_MAX + 1),
  localparam int unsigned ENT_W = TAG_W + GAP_W + POS_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fstk_cmd_t         cmd,
  input  logic [ENT_W-1:0]  ins_entry,
  input  logic [RLIM_W-1:0] report_limit,
  output logic              busy,
  fstk_out_if.source        out_ch
);

  localparam int unsigned CNT_W = $clog2(TOP_K + 1);
  localparam int unsigned IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [CNT_W-1:0]  TOP_C   = CNT_W'(TOP_K);
  localparam logic [RLIM_W-1:0] LIM_CAP = RLIM_W'((REPORT_MAX < TOP_K) ? REPORT_MAX : TOP_K);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_CMP  = 3'd1;
  localparam logic [2:0] ST_INS_PUT  = 3'd2;
  localparam logic [2:0] ST_RPT_LOAD = 3'd3;
  localparam logic [2:0] ST_RPT_NONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  rpt_k_r, rpt_k_nxt;
  logic [CNT_W-1:0]  rpt_n_r, rpt_n_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  pos_m1, pos_m2, cnt_m1, k_p1, lim_c;
  logic [RLIM_W-1:0] lim4;
  logic              better, rpt_last, out_free, load, load_none;

  logic              out_valid_r;
  logic [TAG_W-1:0]  tag_r;
  logic [GAP_W-1:0]  gap_r;
  logic [LEN_OUT_W-1:0] len_r;
  logic              none_r, last_r;

  fstk_ram #(.WIDTH(ENT_W), .DEPTH(TOP_K)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared ranking compare: smaller gap, then shorter symbol
  always_comb begin
    if (ent_r[POS_W +: GAP_W] != ram_rdata[POS_W +: GAP_W]) begin
      better = ent_r[POS_W +: GAP_W] < ram_rdata[POS_W +: GAP_W];
    end else begin
      better = ent_r[0 +: POS_W] < ram_rdata[0 +: POS_W];
    end
  end

  // Helpers for addresses and report length
  always_comb begin
    pos_m1   = pos_r - 1'b1;
    pos_m2   = pos_r - 2'd2;
    cnt_m1   = cnt_r - 1'b1;
    k_p1     = rpt_k_r + 1'b1;
    lim4     = (report_limit == '0) ? 4'd1 :
               ((report_limit > LIM_CAP) ? LIM_CAP : report_limit);
    lim_c    = CNT_W'(lim4);
    rpt_last = (k_p1 == rpt_n_r);
    out_free = !out_valid_r || out_ch.ready;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    rpt_k_nxt = rpt_k_r;
    rpt_n_nxt = rpt_n_r;
    ent_nxt   = ent_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ent_r;
    ram_re    = 1'b0;
    ram_raddr = '0;
    load      = 1'b0;
    load_none = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd.ins) begin
          ent_nxt = ins_entry;
          if (cnt_r == '0) begin
            ram_we    = 1'b1;
            ram_wdata = ins_entry;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            // fetch the current tail and walk upwards
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[IDX_W-1:0];
            pos_nxt   = cnt_r;
            state_nxt = ST_INS_CMP;
          end
        end else if (cmd.rpt) begin
          if (cnt_r == '0) begin
            state_nxt = ST_RPT_NONE;
          end else begin
            ram_re    = 1'b1;
            rpt_k_nxt = '0;
            rpt_n_nxt = (cnt_r < lim_c) ? cnt_r : lim_c;
            state_nxt = ST_RPT_LOAD;
          end
        end
      end

      ST_INS_CMP: begin
        if (better) begin
          // shift the compared entry down one place (dropped past the end)
          if (pos_r < TOP_C) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r[IDX_W-1:0];
            ram_wdata = ram_rdata;
          end
          pos_nxt = pos_m1;
          if (pos_m1 == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_m2[IDX_W-1:0];
          end
        end else begin
          if (pos_r < TOP_C) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r[IDX_W-1:0];
          end
          if (cnt_r < TOP_C) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IDX_W-1:0];
        if (cnt_r < TOP_C) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_RPT_NONE: begin
        if (out_free) begin
          load_none = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_RPT_LOAD: begin
        if (out_free) begin
          load = 1'b1;
          if (rpt_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            rpt_k_nxt = k_p1;
            ram_re    = 1'b1;
            ram_raddr = k_p1[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      rpt_k_r <= '0;
      rpt_n_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      rpt_k_r <= rpt_k_nxt;
      rpt_n_r <= rpt_n_nxt;
    end
  end

  // Pending entry
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load || load_none) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_r  <= ram_rdata[POS_W + GAP_W +: TAG_W];
      gap_r  <= ram_rdata[POS_W +: GAP_W];
      len_r  <= LEN_OUT_W'(ram_rdata[0 +: POS_W]);
      none_r <= 1'b0;
      last_r <= rpt_last;
    end else if (load_none) begin
      tag_r  <= '0;
      gap_r  <= '0;
      len_r  <= '0;
      none_r <= 1'b1;
      last_r <= 1'b1;
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.match_tag     = tag_r;
  assign out_ch.gap_count     = gap_r;
  assign out_ch.symbol_length = len_r;
  assign out_ch.none_found    = none_r;
  assign out_ch.last_result   = last_r;

  // List invariants
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= TOP_C)
    else $error("best count beyond list size");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && none_r) |-> last_r)
    else $error("none-found result not marked final");
  a_ins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_CMP) |-> (cnt_r != '0 && pos_r != '0))
    else $error("compare walk on an empty list");
  a_rpt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RPT_LOAD && load && rpt_last) |=> (cnt_r == '0 && state_r == ST_IDLE))
    else $error("list not cleared after report");

endmodule

// ===== rtl/core/fuzzy_subsequence_top_k_matcher.sv =====
// Top level: configuration registers, input steering, match unit and best-list sequencer.
// A character item is taken when the list is idle; one that closes a qualifying symbol
//   then holds the input (not at all if the list is empty) while one shared comparator
//   walks the list.
// A report item holds the input while its results (one none-found on an empty list) are
//   loaded, longer under output stalls; each result is read from RAM, then registered out.
// Reset (synchronous, rst_n low) empties the list, clears match state and configuration
//   (report limit set to 8); list entries stay, as only counted entries are ever read.
`timescale 1ns / 1ps

module fuzzy_subsequence_top_k_matcher import fstk_pkg::*; #(
  parameter int unsigned QUERY_MAX  = QUERY_MAX_DEF,
  parameter int unsigned SYMBOL_MAX = SYMBOL_MAX_DEF,
  parameter int unsigned TOP_K      = TOP_K_DEF,
  localparam int unsigned POS_W = $clog2(SYMBOL_MAX + 1),
  localparam int unsigned ENT_W = TAG_W + GAP_W + POS_W
) (
  input  logic        clk,
  input  logic        rst_n,
  fstk_in_if.sink     in_ch,
  fstk_out_if.source  out_ch,
  fstk_cfg_if.sink    cfg_ch
);

  fstk_cfg_t        cfg_r;
  fstk_cmd_t        cmd;
  logic             busy;
  logic             in_acc, char_acc;
  logic             ins_valid;
  logic [ENT_W-1:0] ins_entry;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_length <= '0;
      cfg_r.query_chars  <= '0;
      cfg_r.fold_case    <= 1'b0;
      cfg_r.method_sel   <= 1'b0;
      cfg_r.report_limit <= RLIM_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_QUERY_LENGTH: cfg_r.query_length       <= cfg_ch.data[QLEN_W-1:0];
        CFG_QUERY_0_7:    cfg_r.query_chars[7:0]   <= cfg_ch.data;
        CFG_QUERY_8_15:   cfg_r.query_chars[15:8]  <= cfg_ch.data;
        CFG_QUERY_16_23:  cfg_r.query_chars[23:16] <= cfg_ch.data;
        CFG_QUERY_24_31:  cfg_r.query_chars[31:24] <= cfg_ch.data;
        CFG_FOLD_CASE:    cfg_r.fold_case          <= cfg_ch.data[0];
        CFG_METHOD_SEL:   cfg_r.method_sel         <= cfg_ch.data[0];
        CFG_REPORT_LIMIT: cfg_r.report_limit       <= cfg_ch.data[RLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input steering: characters to the match unit, reports to the list
  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && !busy;
  assign char_acc    = in_acc && !in_ch.mode;
  assign cmd.ins     = ins_valid;
  assign cmd.rpt     = in_acc && in_ch.mode;

  fstk_match #(.QUERY_MAX(QUERY_MAX), .SYMBOL_MAX(SYMBOL_MAX)) u_match (
    .clk             (clk),
    .rst_n           (rst_n),
    .char_acc        (char_acc),
    .char_code       (in_ch.char_code),
    .last_of_symbol  (in_ch.last_of_symbol),
    .symbol_is_method(in_ch.symbol_is_method),
    .tag_index       (in_ch.tag_index),
    .cfg             (cfg_r),
    .ins_valid       (ins_valid),
    .ins_entry       (ins_entry)
  );

  fstk_list #(.TOP_K(TOP_K), .SYMBOL_MAX(SYMBOL_MAX)) u_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .ins_entry   (ins_entry),
    .report_limit(cfg_r.report_limit),
    .busy        (busy),
    .out_ch      (out_ch)
  );

  // Steering invariants
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.rpt))
    else $error("insert and report in the same cycle");
  a_busy_after_rpt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rpt |=> busy)
    else $error("report did not start the sequencer");
  a_ins_gated: assert property (@(posedge clk) disable iff (!rst_n)
    ins_valid |-> char_acc)
    else $error("insert without an accepted character");

endmodule

// ===== verif/fuzzy_subsequence_top_k_matcher_test.sv =====
// Self-checking testbench for the fuzzy subsequence top-K matcher.
`timescale 1ns / 1ps

module fuzzy_subsequence_top_k_matcher_test;
  import fstk_pkg::*;

  localparam int unsigned RANK_DEPTH   = TOP_K_DEF;
  localparam int unsigned LEN_CAP      = SYMBOL_MAX_DEF;
  localparam int unsigned DRAIN_CYCLES = TOP_K_DEF + 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic MODE_CHAR   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;
  localparam logic [CHAR_W-1:0] LOWER_A = ASCII_UPPER_A + ASCII_CASE_OFS;
  localparam logic [CHAR_W-1:0] LOWER_Z = ASCII_UPPER_Z + ASCII_CASE_OFS;

  typedef logic [CHAR_W-1:0] sym_t[$];

  // One reported match as it should leave the block
  typedef struct {
    logic [TAG_W-1:0]     tag;
    logic [GAP_W-1:0]     gap;
    logic [LEN_OUT_W-1:0] len;
    logic                 none;
    logic                 closes;
  } hit_t;

  typedef struct {
    logic [TAG_W-1:0] tag;
    int               gap;
    int               len;
  } rank_entry_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  fstk_in_if  in_if();
  fstk_out_if out_if();
  fstk_cfg_if cfg_if();

  fuzzy_subsequence_top_k_matcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor copy of the configuration and match state
  fstk_cfg_t   settings;
  int          q_pos;
  int          last_hit_pos;
  int          sym_pos;
  int          gap_sum;
  bit          hit_seen;
  rank_entry_t ranked [RANK_DEPTH];
  int          ranked_count;

  hit_t        awaited_hits[$];
  reg_write_t  staged_writes[$];

  int errors;
  int items_sent;
  int reports_sent;
  int hits_predicted;
  int hits_checked;
  int reg_writes_done;
  int sink_hold;
  int quiet_cycles;
  bit idle_bursts;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_symbol();
    q_pos        = 0;
    last_hit_pos = 0;
    sym_pos      = 0;
    gap_sum      = 0;
    hit_seen     = 1'b0;
  endfunction

  function automatic void reset_predictor();
    settings              = '0;
    settings.report_limit = RLIM_RST;
    ranked_count          = 0;
    clear_symbol();
  endfunction

  function automatic void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    int base;
    base = 8 * (int'(idx) - int'(CFG_QUERY_0_7));
    case (idx)
      CFG_QUERY_LENGTH: settings.query_length = data[QLEN_W-1:0];
      CFG_QUERY_0_7, CFG_QUERY_8_15, CFG_QUERY_16_23, CFG_QUERY_24_31: begin
        for (int k = 0; k < 8; k++) settings.query_chars[base + k] = data[8*k +: 8];
      end
      CFG_FOLD_CASE:    settings.fold_case    = data[0];
      CFG_METHOD_SEL:   settings.method_sel   = data[0];
      CFG_REPORT_LIMIT: settings.report_limit = data[RLIM_W-1:0];
      default: ;
    endcase
  endfunction

  // query length in use; register values beyond the store act as full
  function automatic int query_span();
    return (settings.query_length > QUERY_MAX_DEF) ? QUERY_MAX_DEF : int'(settings.query_length);
  endfunction

  function automatic bit outranks(rank_entry_t a, rank_entry_t b);
    if (a.gap != b.gap) return a.gap < b.gap;
    return a.len < b.len;
  endfunction

  // sorted insert; equal entries queue behind, a full list drops the last
  function automatic void rank_insert(rank_entry_t e);
    int slot;
    int top;
    slot = ranked_count;
    while (slot > 0 && outranks(e, ranked[slot-1])) slot--;
    if (slot < RANK_DEPTH) begin
      top = (ranked_count < RANK_DEPTH) ? ranked_count : RANK_DEPTH - 1;
      for (int k = top; k > slot; k--) ranked[k] = ranked[k-1];
      ranked[slot] = e;
      if (ranked_count < RANK_DEPTH) ranked_count++;
    end
  endfunction

  function automatic void predict_item(logic mode, logic [CHAR_W-1:0] c, logic eos,
                                       logic meth, logic [TAG_W-1:0] tag);
    int          span;
    int          lim;
    int          n;
    int          g;
    logic [CHAR_W-1:0] ch;
    hit_t        h;
    rank_entry_t e;
    span = query_span();
    if (mode == MODE_REPORT) begin
      reports_sent++;
      lim = settings.report_limit;
      if (lim < 1) lim = 1;
      if (lim > REPORT_MAX) lim = REPORT_MAX;
      if (lim > RANK_DEPTH) lim = RANK_DEPTH;
      if (ranked_count == 0) begin
        h.tag    = '0;
        h.gap    = '0;
        h.len    = '0;
        h.none   = 1'b1;
        h.closes = 1'b1;
        awaited_hits.insert(awaited_hits.size(), h);
        hits_predicted++;
      end else begin
        n = (ranked_count < lim) ? ranked_count : lim;
        for (int k = 0; k < n; k++) begin
          h.tag    = ranked[k].tag;
          h.gap    = GAP_W'(ranked[k].gap);
          h.len    = LEN_OUT_W'(ranked[k].len);
          h.none   = 1'b0;
          h.closes = (k == n - 1);
          awaited_hits.insert(awaited_hits.size(), h);
          hits_predicted++;
        end
        ranked_count = 0;
      end
    end else begin
      ch = c;
      if (settings.fold_case && ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
        ch = ch + ASCII_CASE_OFS;
      if (q_pos < span && ch == settings.query_chars[q_pos]) begin
        // a repeat match at the saturated position adds no gap
        if (hit_seen && sym_pos > last_hit_pos) begin
          g = gap_sum + sym_pos - last_hit_pos - 1;
          gap_sum = (g > int'(GAP_SAT)) ? int'(GAP_SAT) : g;
        end
        last_hit_pos = sym_pos;
        hit_seen     = 1'b1;
        q_pos++;
      end
      if (sym_pos < LEN_CAP) sym_pos++;
      if (eos) begin
        if (meth == settings.method_sel && q_pos >= span) begin
          e.tag = tag;
          e.gap = gap_sum;
          e.len = sym_pos;
          rank_insert(e);
        end
        clear_symbol();
      end
    end
  endfunction

  // ---------------------------------------------------------------- result side

  // Result checker: every transfer is matched against the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected result tag %h", out_if.match_tag));
      end else begin
        want = awaited_hits.pop_front();
        hits_checked++;
        if (out_if.match_tag !== want.tag)
          flag_mismatch($sformatf("match_tag %h, want %h", out_if.match_tag, want.tag));
        if (out_if.gap_count !== want.gap)
          flag_mismatch($sformatf("gap_count %0d, want %0d", out_if.gap_count, want.gap));
        if (out_if.symbol_length !== want.len)
          flag_mismatch($sformatf("symbol_length %0d, want %0d", out_if.symbol_length,
                                  want.len));
        if (out_if.none_found !== want.none)
          flag_mismatch($sformatf("none_found %b, want %b", out_if.none_found, want.none));
        if (out_if.last_result !== want.closes)
          flag_mismatch($sformatf("last_result %b, want %b", out_if.last_result,
                                  want.closes));
      end
    end
  end

  // Result-side back-pressure in random bursts while idle_bursts is set
  initial begin
    out_if.ready <= 1'b0;
    sink_hold = 0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        sink_hold = $urandom_range(1, 19) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic hold_off(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // idle means no result outstanding and any list walk finished
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (awaited_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic mode, logic [CHAR_W-1:0] c, logic eos, logic meth,
                           logic [TAG_W-1:0] tag);
    in_if.valid            <= 1'b1;
    in_if.mode             <= mode;
    in_if.char_code        <= c;
    in_if.last_of_symbol   <= eos;
    in_if.symbol_is_method <= meth;
    in_if.tag_index        <= tag;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
    predict_item(mode, c, eos, meth, tag);
    if (idle_bursts && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 19));
  endtask

  // report item; the remaining fields are don't-care and get random values
  task automatic send_report();
    send_item(MODE_REPORT, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // method flag and tag only count on the final character
  task automatic send_symbol(sym_t s, logic meth, logic [TAG_W-1:0] tag, bit cut_in = 1'b0);
    for (int i = 0; i < s.size(); i++) begin
      if (i == s.size() - 1) begin
        if (cut_in && i > 0) send_report();
        send_item(MODE_CHAR, s[i], 1'b1, meth, tag);
      end else begin
        send_item(MODE_CHAR, s[i], 1'b0, 1'($urandom), 16'($urandom));
      end
    end
  endtask

  function automatic void stage(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    staged_writes.insert(staged_writes.size(), w);
  endfunction

  // register writes go out only once the block is idle
  task automatic commit_regs();
    reg_write_t w;
    wait_idle();
    while (staged_writes.size() != 0) begin
      w = staged_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.data;
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
      note_register(w.idx, w.data);
      reg_writes_done++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void load_query(sym_t q, logic [CFG_DAT_W-1:0] len_word);
    logic [CFG_DAT_W-1:0] words [4];
    for (int w = 0; w < 4; w++) words[w] = '0;
    for (int i = 0; i < q.size() && i < 32; i++) words[i/8][8*(i%8) +: 8] = q[i];
    stage(CFG_QUERY_0_7,    words[0]);
    stage(CFG_QUERY_8_15,   words[1]);
    stage(CFG_QUERY_16_23,  words[2]);
    stage(CFG_QUERY_24_31,  words[3]);
    stage(CFG_QUERY_LENGTH, len_word);
  endfunction

  function automatic void plain_settings(logic [CFG_DAT_W-1:0] limit);
    stage(CFG_FOLD_CASE,    64'd0);
    stage(CFG_METHOD_SEL,   64'd0);
    stage(CFG_REPORT_LIMIT, limit);
  endfunction

  function automatic sym_t text(string s);
    sym_t r;
    for (int i = 0; i < s.len(); i++) r.insert(r.size(), s[i]);
    return r;
  endfunction

  // filler: mostly letters near the query alphabet, sometimes any byte
  function automatic logic [CHAR_W-1:0] filler();
    logic [CHAR_W-1:0] ch;
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    ch = LOWER_A + 8'($urandom_range(0, 5));
    if ($urandom_range(0, 1)) ch = ch - ASCII_CASE_OFS;
    return ch;
  endfunction

  // symbol that carries the query with filler; broken drops one query character
  function automatic sym_t shaped_symbol(bit broken);
    sym_t s;
    logic [CHAR_W-1:0] ch;
    int span;
    int skip;
    span = query_span();
    skip = (broken && span > 0) ? int'($urandom_range(0, span - 1)) : -1;
    for (int i = 0; i < span; i++) begin
      repeat ($urandom_range(0, 2)) s.insert(s.size(), filler());
      ch = settings.query_chars[i];
      if (settings.fold_case && ch >= LOWER_A && ch <= LOWER_Z && $urandom_range(0, 1))
        ch = ch - ASCII_CASE_OFS;
      if (i != skip) s.insert(s.size(), ch);
    end
    repeat ($urandom_range(0, 2)) s.insert(s.size(), filler());
    if (s.size() == 0) s.insert(s.size(), filler());
    return s;
  endfunction

  function automatic sym_t noise_symbol();
    sym_t s;
    repeat ($urandom_range(1, 8)) s.insert(s.size(), 8'($urandom));
    return s;
  endfunction

  // ---------------------------------------------------------------- tests

  // plain matching, case folding, method filter, report on an empty list
  task automatic test_basic_matching();
    load_query(text("ab"), 64'd2);
    plain_settings(64'd8);
    commit_regs();
    send_report();
    send_symbol(text("xaQb"), 1'b0, 16'h0000);
    send_symbol(text("AB"), 1'b0, 16'hFFFF);
    send_symbol(text("ab"), 1'b1, 16'h1234);
    send_report();
    // sender holds off until every result is back
    wait_idle();
    stage(CFG_FOLD_CASE, 64'd1);
    stage(CFG_METHOD_SEL, 64'd1);
    commit_regs();
    send_symbol(text("AzB"), 1'b1, 16'hFFFF);
    send_symbol(text("ab"), 1'b0, 16'h0001);
    send_report();
  endtask

  // query bytes at the ends of the byte range, case folding leaves them alone
  task automatic test_byte_extremes();
    sym_t q;
    sym_t s;
    q = {8'hFF, 8'h00, 8'h80, 8'h7F};
    s = {8'hFF, 8'h01, 8'h00, ASCII_UPPER_Z, 8'h80, 8'h7F};
    load_query(q, 64'd4);
    stage(CFG_FOLD_CASE, 64'd1);
    stage(CFG_METHOD_SEL, 64'd1);
    stage(CFG_REPORT_LIMIT, 64'd8);
    commit_regs();
    send_symbol(s, 1'b1, 16'hA5A5);
    send_report();
  endtask

  // zero-length query: every symbol of the right kind matches with no gap
  task automatic test_empty_query();
    load_query(text(""), 64'd0);
    plain_settings(64'd8);
    commit_regs();
    send_symbol(text("zzzz"), 1'b0, 16'd6);
    send_symbol(text("q"), 1'b0, 16'd5);
    send_symbol(text("r"), 1'b1, 16'd7);
    send_report();
  endtask

  // all 32 query slots, length register above the store size
  task automatic test_full_query();
    sym_t q;
    sym_t s;
    for (int i = 0; i < 32; i++) q.insert(q.size(), 8'($urandom));
    load_query(q, {58'($urandom), 6'd63});
    plain_settings(64'd8);
    commit_regs();
    for (int i = 0; i < 32; i++) begin
      if (i % 4 == 1) s.insert(s.size(), 8'($urandom));
      s.insert(s.size(), q[i]);
    end
    send_symbol(s, 1'b0, 16'h5A5A);
    void'(s.pop_back());
    send_symbol(s, 1'b0, 16'hC3C3);
    send_report();
  endtask

  // equal entries keep arrival order; a full list takes only a strictly better one
  task automatic test_ties_and_displacement();
    load_query(text("k"), 64'd1);
    plain_settings(64'd8);
    commit_regs();
    for (int t = 1; t <= 8; t++) send_symbol(text("ak"), 1'b0, 16'(t));
    send_symbol(text("zk"), 1'b0, 16'd9);
    send_symbol(text("k"), 1'b0, 16'd10);
    send_report();
  endtask

  // report limit inside range, at zero and above the list size
  task automatic test_report_limits();
    load_query(text("kz"), 64'd2);
    plain_settings(64'd3);
    commit_regs();
    send_symbol(text("kz"), 1'b0, 16'd1);
    send_symbol(text("kaz"), 1'b0, 16'd2);
    send_symbol(text("kaaz"), 1'b0, 16'd3);
    send_symbol(text("kbz"), 1'b0, 16'd4);
    send_symbol(text("kz"), 1'b0, 16'd5);
    send_report();
    send_report();
    stage(CFG_REPORT_LIMIT, 64'd0);
    commit_regs();
    send_symbol(text("kaz"), 1'b0, 16'd6);
    send_symbol(text("kz"), 1'b0, 16'd7);
    send_report();
    stage(CFG_REPORT_LIMIT, 64'd15);
    commit_regs();
    for (int t = 8; t <= 16; t++) send_symbol((t % 2) ? text("kaz") : text("kz"), 1'b0, 16'(t));
    send_report();
  endtask

  // query length cut below the matched prefix while a symbol is open
  task automatic test_query_shortened();
    load_query(text("abc"), 64'd3);
    plain_settings(64'd8);
    commit_regs();
    send_item(MODE_CHAR, "a", 1'b0, 1'b0, 16'd0);
    send_item(MODE_CHAR, "b", 1'b0, 1'b0, 16'd0);
    stage(CFG_QUERY_LENGTH, 64'd1);
    commit_regs();
    send_item(MODE_CHAR, "z", 1'b1, 1'b0, 16'h0BCD);
    send_report();
  endtask

  // report between characters leaves the open symbol alone
  task automatic test_report_mid_symbol();
    load_query(text("ab"), 64'd2);
    plain_settings(64'd8);
    commit_regs();
    send_symbol(text("axb"), 1'b0, 16'h00FF, 1'b1);
    send_report();
  endtask

  // symbols beyond the length cap: saturated length and gap
  task automatic test_long_symbols();
    sym_t s;
    load_query(text("ab"), 64'd2);
    plain_settings(64'd8);
    commit_regs();
    s = text("a");
    repeat (1100) s.insert(s.size(), "c");
    s.insert(s.size(), "b");
    send_symbol(s, 1'b0, 16'h1111);
    send_report();
    // second and third query bytes both land on the saturated position
    load_query(text("xyz"), 64'd3);
    commit_regs();
    s = text("cccccx");
    repeat (1030) s.insert(s.size(), "c");
    s.insert(s.size(), "y");
    s.insert(s.size(), "z");
    send_symbol(s, 1'b0, 16'h2222);
    send_report();
  endtask

  task automatic random_settings();
    sym_t q;
    int pick;
    int qlen;
    pick = $urandom_range(0, 9);
    if (pick == 0)      qlen = 0;
    else if (pick == 1) qlen = $urandom_range(33, 63);
    else if (pick == 2) qlen = 32;
    else                qlen = $urandom_range(1, 5);
    for (int i = 0; i < 32; i++) begin
      if (i < qlen && $urandom_range(0, 9) != 0)
        q.insert(q.size(), LOWER_A + 8'($urandom_range(0, 5)));
      else
        q.insert(q.size(), 8'($urandom));
    end
    load_query(q, {58'($urandom), 6'(qlen)});
    stage(CFG_FOLD_CASE,    {$urandom, $urandom});
    stage(CFG_METHOD_SEL,   {$urandom, $urandom});
    stage(CFG_REPORT_LIMIT, {60'($urandom), 4'($urandom_range(0, 15))});
    commit_regs();
  endtask

  // random phases: fresh settings, mostly query-shaped symbols, frequent reports
  task automatic test_random_traffic(int item_goal, int hit_goal);
    int   first_item;
    int   first_hit;
    int   kind;
    logic meth;
    sym_t s;
    first_item = items_sent;
    first_hit  = hits_predicted;
    while (items_sent - first_item < item_goal || hits_predicted - first_hit < hit_goal) begin
      random_settings();
      repeat (10) begin
        kind = $urandom_range(0, 7);
        if (kind < 5)      s = shaped_symbol(1'b0);
        else if (kind < 7) s = shaped_symbol(1'b1);
        else               s = noise_symbol();
        meth = ($urandom_range(0, 3) != 0) ? settings.method_sel : !settings.method_sel;
        send_symbol(s, meth, 16'($urandom), $urandom_range(0, 11) == 0);
        if ($urandom_range(0, 2) == 0) send_report();
      end
      send_report();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    errors          = 0;
    items_sent      = 0;
    reports_sent    = 0;
    hits_predicted  = 0;
    hits_checked    = 0;
    reg_writes_done = 0;
    idle_bursts     = 1'b1;
    reset_predictor();

    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.mode             <= MODE_CHAR;
    in_if.char_code        <= '0;
    in_if.last_of_symbol   <= 1'b0;
    in_if.symbol_is_method <= 1'b0;
    in_if.tag_index        <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CFG_QUERY_LENGTH;
    cfg_if.data            <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_matching();
    test_byte_extremes();
    test_empty_query();
    test_full_query();
    test_ties_and_displacement();
    test_report_limits();
    test_query_shortened();
    test_report_mid_symbol();
    test_long_symbols();
    test_random_traffic(300, 40);
    // closing stretch at full rate on both sides
    idle_bursts = 1'b0;
    test_random_traffic(120, 12);
    wait_idle();

    $display("Run covered %0d input transfers (%0d reports), %0d register writes, %0d results",
             items_sent, reports_sent, reg_writes_done, hits_checked);
    $display("Included: empty and over-long queries, ties, saturation, mid-symbol changes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fstk_pkg.sv
rtl/core/fstk_if.sv
rtl/core/fstk_ram.sv
rtl/core/fstk_match.sv
rtl/core/fstk_list.sv
rtl/core/fuzzy_subsequence_top_k_matcher.sv
verif/fuzzy_subsequence_top_k_matcher_test.sv
